// ----- src/twrf_pkg.sv -----
// twrf_pkg: shared types and constants for the two-wire register master
// command codes, result kinds, frame bytes and request/result/job structs
// no dependencies
package twrf_pkg;

  localparam int ON_CYCLES_DEF = 32;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [2:0] CMD_ON        = 3'd0;
  localparam logic [2:0] CMD_WRITE     = 3'd1;
  localparam logic [2:0] CMD_READ      = 3'd2;
  localparam logic [2:0] CMD_OFF       = 3'd3;
  localparam logic [2:0] CMD_SOFT_RST  = 3'd4;
  localparam logic [2:0] CMD_RST       = 3'd5;
  localparam logic [2:0] CMD_BATT_READ = 3'd6;
  localparam logic [2:0] CMD_WAKE      = 3'd7;

  localparam logic [1:0] KIND_CYCLE = 2'd0;
  localparam logic [1:0] KIND_WAKE  = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  localparam logic [7:0] FRAME_ADDR    = 8'hFE;
  localparam logic [7:0] OFF_CODE      = 8'h02;
  localparam logic [7:0] SOFT_RST_CODE = 8'h04;
  localparam logic [7:0] RST_CODE      = 8'h01;
  localparam logic [7:0] WR_FLAG       = 8'h80;
  localparam logic [5:0] BATT_ADDR     = 6'h3E;

  typedef struct packed {
    logic [2:0] command;
    logic [5:0] address;
    logic [7:0] data;
    logic [7:0] reply_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       data_bit;
    logic       data_driven;
    logic [7:0] read_data;
    logic       status;
    logic       link_active;
    logic       last;
  } out_item_t;

  // one classified request, as handed from front to back
  typedef struct packed {
    logic       send_on;
    logic       frame;
    logic       rx_release;
    logic       wake;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] read_data;
    logic       status;
    logic       link;
  } job_t;

endpackage

// ----- src/two_wire_rf_config_master.sv -----
// Two-wire register master: each accepted request becomes a run of bus
// clock-cycle results ending in one completion result: on sends the power-on
// sequence, write/read/off/soft reset/reset a two-byte frame, wake one wake
// result, battery read the frame after the power-on sequence if the link is
// idle; a disabled driver gives only the completion. The back-end sequencer
// emits one result per cycle unless the output stalls; a two-entry queue lets
// the host hand over further requests meanwhile. The user must write enable
// through cfg_we/cfg_wdata only while idle; the block does not enforce it.
module two_wire_rf_config_master #(
  parameter int ON_CYCLES = twrf_pkg::ON_CYCLES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  twrf_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output twrf_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic                cfg_wdata
);
  import twrf_pkg::*;

  logic push, pop, q_full, q_valid;
  job_t push_job, q_job;

  twrf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .push      (push),
    .job       (push_job)
  );

  twrf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  twrf_back #(
    .ON_CYCLES (ON_CYCLES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ----- src/twrf_front.sv -----
// twrf_front: accepts requests, holds enable and link state, classifies
// each request into a job for the back end
// depends on twrf_pkg
module twrf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  twrf_pkg::in_item_t in_item,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              q_full,
  output logic              push,
  output twrf_pkg::job_t    job
);
  import twrf_pkg::*;

  logic enable_r, enable_nxt;
  logic link_r, link_nxt;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    job = '0;
    job.link = link_r;
    if (!enable_r) begin
      job.status = 1'b1;
    end else begin
      case (in_item.command)
        CMD_ON: begin
          job.send_on = 1'b1;
          job.link    = 1'b1;
        end
        CMD_WRITE: begin
          job.frame = 1'b1;
          job.byte0 = WR_FLAG | {1'b0, in_item.address, 1'b0};
          job.byte1 = in_item.data;
        end
        CMD_READ: begin
          job.frame      = 1'b1;
          job.rx_release = 1'b1;
          job.byte0      = {1'b0, in_item.address, 1'b0};
          job.read_data  = in_item.reply_byte;
        end
        CMD_OFF: begin
          job.frame = 1'b1;
          job.byte0 = FRAME_ADDR;
          job.byte1 = OFF_CODE;
          job.link  = 1'b0;
        end
        CMD_SOFT_RST: begin
          job.frame = 1'b1;
          job.byte0 = FRAME_ADDR;
          job.byte1 = SOFT_RST_CODE;
          job.link  = 1'b0;
        end
        CMD_RST: begin
          job.frame = 1'b1;
          job.byte0 = FRAME_ADDR;
          job.byte1 = RST_CODE;
          job.link  = 1'b1;
        end
        CMD_BATT_READ: begin
          job.send_on    = !link_r;
          job.frame      = 1'b1;
          job.rx_release = 1'b1;
          job.byte0      = {1'b0, BATT_ADDR, 1'b0};
          job.read_data  = in_item.reply_byte;
          job.link       = 1'b1;
        end
        CMD_WAKE: begin
          job.wake = 1'b1;
        end
        default: begin
          job.wake = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    enable_nxt = enable_r;
    link_nxt   = link_r;
    if (cfg_we) begin
      enable_nxt = cfg_wdata;
      if (!cfg_wdata) link_nxt = 1'b0;
    end else if (push) begin
      link_nxt = job.link;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      link_r   <= 1'b0;
    end else begin
      enable_r <= enable_nxt;
      link_r   <= link_nxt;
    end
  end

endmodule

// ----- src/twrf_queue.sv -----
// twrf_queue: short job queue between front and back
// depends on twrf_pkg
module twrf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  twrf_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output twrf_pkg::job_t q_job
);
  import twrf_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_job   = entry_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_job;
  end

endmodule

// ----- src/twrf_back.sv -----
// twrf_back: sequencer that plays one job out as bus cycles and a completion
// into the output register
// depends on twrf_pkg
module twrf_back #(
  parameter int ON_CYCLES = twrf_pkg::ON_CYCLES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  twrf_pkg::job_t      q_job,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output twrf_pkg::out_item_t out_item
);
  import twrf_pkg::*;

  localparam int ON_W  = (ON_CYCLES > 1) ? $clog2(ON_CYCLES) : 1;
  localparam int CNT_W = (ON_W > 4) ? ON_W : 4;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ON    = 5'b00010,
    S_FRAME = 5'b00100,
    S_WAKE  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  job_t             job_r, job_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;
  logic             can_emit;
  out_item_t        cyc;

  assign can_emit  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    cyc             = '0;
    cyc.kind        = KIND_CYCLE;
    cyc.data_driven = 1'b1;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    job_nxt       = job_r;
    pop           = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          pop     = 1'b1;
          job_nxt = q_job;
          cnt_nxt = '0;
          if (q_job.send_on) state_nxt = S_ON;
          else if (q_job.frame) state_nxt = S_FRAME;
          else if (q_job.wake) state_nxt = S_WAKE;
          else state_nxt = S_DONE;
        end
      end
      S_ON: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = cyc;
          if (cnt_r == CNT_W'(ON_CYCLES - 1)) begin
            cnt_nxt   = '0;
            state_nxt = job_r.frame ? S_FRAME : S_DONE;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      S_FRAME: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = cyc;
          if (!cnt_r[3]) begin
            out_item_nxt.data_bit = job_r.byte0[~cnt_r[2:0]];
          end else if (job_r.rx_release) begin
            out_item_nxt.data_driven = 1'b0;
          end else begin
            out_item_nxt.data_bit = job_r.byte1[~cnt_r[2:0]];
          end
          if (cnt_r[3:0] == 4'd15) begin
            cnt_nxt   = '0;
            state_nxt = S_DONE;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      S_WAKE: begin
        if (can_emit) begin
          out_valid_nxt     = 1'b1;
          out_item_nxt      = cyc;
          out_item_nxt.kind = KIND_WAKE;
          state_nxt         = S_DONE;
        end
      end
      S_DONE: begin
        if (can_emit) begin
          out_valid_nxt            = 1'b1;
          out_item_nxt             = cyc;
          out_item_nxt.kind        = KIND_DONE;
          out_item_nxt.read_data   = job_r.read_data;
          out_item_nxt.status      = job_r.status;
          out_item_nxt.link_active = job_r.link;
          out_item_nxt.last        = 1'b1;
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

// ----- src/twrf_checker.sv -----
// twrf_checker: port-level assertions for the two-wire register master
// depends on twrf_pkg; bound to two_wire_rf_config_master
module twrf_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input twrf_pkg::out_item_t out_item
);
  import twrf_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  a_last_is_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last |-> out_item.kind == KIND_DONE && out_item.data_driven)
    else $error("last on a non-completion result");

  a_not_init_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status |-> out_item.read_data == 8'd0 && out_item.last)
    else $error("not-initialized completion carries data");

  a_released_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.data_driven |-> !out_item.data_bit && out_item.kind == KIND_CYCLE)
    else $error("released cycle with data bit set");

endmodule

bind two_wire_rf_config_master twrf_checker u_twrf_checker (.*);

// ----- test/tb_top.sv -----
// tb_top: self-checking bench for two_wire_rf_config_master, with a directed table then random
// phases under sender gaps, receiver stalls and a long receiver hold-off, checked per bus cycle
// depends on twrf_pkg and two_wire_rf_config_master
module tb_top;
  import twrf_pkg::*;

  typedef struct packed {
    logic      is_cfg;
    logic      cfg_val;
    in_item_t  req;
    logic      typed;
    out_item_t res;
  } row_t;

  localparam out_item_t NOT_INIT_DONE = '{kind: KIND_DONE, data_bit: 1'b0, data_driven: 1'b1,
                                          read_data: 8'h00, status: 1'b1, link_active: 1'b0,
                                          last: 1'b1};

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;
  logic      cfg_we;
  logic      cfg_wdata;

  logic      model_enable;
  logic      model_link;
  out_item_t bus_cycles_due[$];
  row_t      req_plan[$];
  row_t      dir_rows[$];
  row_t      plan_head;
  out_item_t want;
  int        mismatches;
  int        results_seen;
  int        stall_pct;
  int        hold_cycles;

  two_wire_rf_config_master dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic string fmt_item(out_item_t r);
    return $sformatf("kind %0d bit %0b driven %0b read %02h status %0b link %0b last %0b",
                     r.kind, r.data_bit, r.data_driven, r.read_data, r.status,
                     r.link_active, r.last);
  endfunction

  function automatic void push_result(logic [1:0] kind, logic lvl, logic drv, logic [7:0] rd,
                                      logic st, logic lk, logic lst);
    out_item_t r;
    r = '{kind: kind, data_bit: lvl, data_driven: drv, read_data: rd, status: st,
          link_active: lk, last: lst};
    bus_cycles_due.push_back(r);
  endfunction

  function automatic void push_byte(logic [7:0] b);
    for (int i = 7; i >= 0; i--) push_result(KIND_CYCLE, b[i], 1'b1, 8'h00, 1'b0, 1'b0, 1'b0);
  endfunction

  function automatic void push_release();
    for (int i = 0; i < 8; i++) push_result(KIND_CYCLE, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
  endfunction

  function automatic void push_on();
    for (int i = 0; i < ON_CYCLES_DEF; i++)
      push_result(KIND_CYCLE, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0);
    model_link = 1'b1;
  endfunction

  // bus cycles and completion caused by one request
  function automatic void frame_for_request(in_item_t req);
    logic [7:0] rd;
    rd = 8'h00;
    if (!model_enable) begin
      push_result(KIND_DONE, 1'b0, 1'b1, 8'h00, 1'b1, model_link, 1'b1);
      return;
    end
    case (req.command)
      CMD_ON: push_on();
      CMD_WRITE: begin
        push_byte(WR_FLAG | {1'b0, req.address, 1'b0});
        push_byte(req.data);
      end
      CMD_READ: begin
        push_byte({1'b0, req.address, 1'b0});
        push_release();
        rd = req.reply_byte;
      end
      CMD_OFF: begin
        push_byte(FRAME_ADDR);
        push_byte(OFF_CODE);
        model_link = 1'b0;
      end
      CMD_SOFT_RST: begin
        push_byte(FRAME_ADDR);
        push_byte(SOFT_RST_CODE);
        model_link = 1'b0;
      end
      CMD_RST: begin
        push_byte(FRAME_ADDR);
        push_byte(RST_CODE);
        model_link = 1'b1;
      end
      CMD_BATT_READ: begin
        if (!model_link) push_on();
        push_byte({1'b0, BATT_ADDR, 1'b0});
        push_release();
        rd = req.reply_byte;
      end
      default: begin
        push_result(KIND_WAKE, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0);
      end
    endcase
    push_result(KIND_DONE, 1'b0, 1'b1, rd, 1'b0, model_link, 1'b1);
  endfunction

  function automatic row_t req_row(logic [2:0] cmd, logic [5:0] addr, logic [7:0] data,
                                   logic [7:0] reply);
    row_t r;
    r = '0;
    r.req = '{command: cmd, address: addr, data: data, reply_byte: reply};
    return r;
  endfunction

  function automatic row_t typed_row(logic [2:0] cmd, logic [5:0] addr, logic [7:0] data,
                                     logic [7:0] reply, out_item_t res);
    row_t r;
    r = req_row(cmd, addr, data, reply);
    r.typed = 1'b1;
    r.res = res;
    return r;
  endfunction

  function automatic row_t cfg_row(logic v);
    row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.cfg_val = v;
    return r;
  endfunction

  // acceptance, prediction and checking, all on the sampled edge values
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        model_enable = cfg_wdata;
        if (!cfg_wdata) model_link = 1'b0;
      end
      if (in_valid && !in_stall) begin
        plan_head = req_plan.pop_front();
        if (plan_head.typed) bus_cycles_due.push_back(plan_head.res);
        else frame_for_request(in_item);
      end
      if (out_valid && !out_stall) begin
        if (bus_cycles_due.size() == 0) begin
          if (mismatches < 10)
            $display("tb_top: result %0d unexpected, got %s", results_seen, fmt_item(out_item));
          mismatches++;
        end else begin
          want = bus_cycles_due.pop_front();
          if (out_item.kind !== want.kind || out_item.data_bit !== want.data_bit ||
              out_item.data_driven !== want.data_driven ||
              out_item.read_data !== want.read_data || out_item.status !== want.status ||
              out_item.link_active !== want.link_active || out_item.last !== want.last) begin
            if (mismatches < 10) begin
              $display("tb_top: result %0d mismatch", results_seen);
              $display("  expected %s", fmt_item(want));
              $display("  actual   %s", fmt_item(out_item));
            end
            mismatches++;
          end
        end
        results_seen++;
      end
    end
  end

  // receiver side: random stall, or a counted hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic offer_request(input row_t row, input int idle_pct);
    req_plan.push_back(row);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= row.req;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (bus_cycles_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_enable(input logic v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int count, input int idle_pct, input int stall_v);
    row_t r;
    stall_pct = stall_v;
    for (int i = 0; i < count; i++) begin
      r = req_row(3'($urandom_range(7)), 6'($urandom_range(63)), 8'($urandom_range(255)),
                  8'($urandom_range(255)));
      offer_request(r, idle_pct);
    end
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    model_enable = 1'b0;
    model_link = 1'b0;
    mismatches = 0;
    results_seen = 0;
    stall_pct = 0;
    hold_cycles = 0;

    // disabled after reset, then every command, then disabled again and re-enabled
    dir_rows.push_back(typed_row(CMD_WAKE, 6'd63, 8'hFF, 8'hFF, NOT_INIT_DONE));
    dir_rows.push_back(typed_row(CMD_ON, 6'd0, 8'h00, 8'h00, NOT_INIT_DONE));
    dir_rows.push_back(cfg_row(1'b1));
    dir_rows.push_back(req_row(CMD_WAKE, 6'd0, 8'h00, 8'h00));
    dir_rows.push_back(req_row(CMD_BATT_READ, 6'd0, 8'h00, 8'hA5));
    dir_rows.push_back(req_row(CMD_BATT_READ, 6'd63, 8'hFF, 8'h5A));
    dir_rows.push_back(req_row(CMD_WRITE, 6'd0, 8'h00, 8'h00));
    dir_rows.push_back(req_row(CMD_WRITE, 6'd63, 8'hFF, 8'hFF));
    dir_rows.push_back(req_row(CMD_READ, 6'd63, 8'hFF, 8'hFF));
    dir_rows.push_back(req_row(CMD_READ, 6'd0, 8'h00, 8'h00));
    dir_rows.push_back(req_row(CMD_OFF, 6'd21, 8'h55, 8'hAA));
    dir_rows.push_back(req_row(CMD_READ, 6'd42, 8'h00, 8'h81));
    dir_rows.push_back(req_row(CMD_SOFT_RST, 6'd0, 8'h00, 8'h00));
    dir_rows.push_back(req_row(CMD_RST, 6'd63, 8'hFF, 8'hFF));
    dir_rows.push_back(req_row(CMD_ON, 6'd0, 8'h00, 8'h00));
    dir_rows.push_back(req_row(CMD_WAKE, 6'd63, 8'hFF, 8'hFF));
    dir_rows.push_back(cfg_row(1'b0));
    dir_rows.push_back(typed_row(CMD_WRITE, 6'd63, 8'hFF, 8'hFF, NOT_INIT_DONE));
    dir_rows.push_back(typed_row(CMD_BATT_READ, 6'd0, 8'h00, 8'h00, NOT_INIT_DONE));
    dir_rows.push_back(cfg_row(1'b1));
    dir_rows.push_back(req_row(CMD_BATT_READ, 6'd0, 8'h00, 8'h00));
    dir_rows.push_back(req_row(CMD_READ, 6'd21, 8'hAA, 8'h3C));
    dir_rows.push_back(req_row(CMD_ON, 6'd63, 8'hFF, 8'hFF));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_enable(dir_rows[i].cfg_val);
      else offer_request(dir_rows[i], 0);
    end
    drain();

    run_random(110, 0, 0);
    run_random(110, 78, 0);
    run_random(100, 0, 78);
    run_random(100, 20, 20);
    write_enable(1'b0);
    run_random(20, 20, 20);
    write_enable(1'b1);

    // receiver holds off while the sender keeps offering
    stall_pct = 0;
    hold_cycles = 400;
    run_random(16, 0, 0);

    stall_pct = 0;
    repeat (60) @(posedge clk);
    if (mismatches == 0 && bus_cycles_due.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
